### design/ptt_pkg.sv
// shared types and codes of the periodic timer table
package ptt_pkg;

	localparam int PTT_DEPTH = 128;

	localparam logic [3:0] K_TICK     = 4'd0;
	localparam logic [3:0] K_CREATE   = 4'd1;
	localparam logic [3:0] K_POLL     = 4'd2;
	localparam logic [3:0] K_POLL_ANY = 4'd3;
	localparam logic [3:0] K_IS_DUE   = 4'd4;
	localparam logic [3:0] K_UNTIL    = 4'd5;
	localparam logic [3:0] K_CANCEL   = 4'd6;
	localparam logic [3:0] K_CANCEL_T = 4'd7;
	localparam logic [3:0] K_STATS    = 4'd8;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic        live;
		logic [3:0]  etype;
		logic [7:0]  card;
		logic [15:0] chan;
		logic [30:0] period;
		logic [31:0] deadline;
	} entry_t;

	typedef struct packed {
		logic        live;
		logic        match;
		logic        type_hit;
		logic        due;
		logic [31:0] gap;
	} eval_t;

endpackage

### design/ptt_if.sv
// request, response and configuration channels
interface ptt_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         kind;
	logic [3:0]         timer_type;
	logic signed [8:0]  card_sel;
	logic signed [16:0] channel_sel;
	logic [30:0]        period_ms;
	modport source(output valid, kind, timer_type, card_sel, channel_sel, period_ms,
		input ready);
	modport sink(input valid, kind, timer_type, card_sel, channel_sel, period_ms,
		output ready);
endinterface

interface ptt_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [6:0]         slot;
	logic [3:0]         found_type;
	logic [7:0]         found_card;
	logic [15:0]        found_channel;
	logic signed [31:0] wait_ms;
	logic [7:0]         cancel_count;
	logic [7:0]         total_count;
	logic [7:0]         live_count;
	logic [7:0]         due_count;
	modport source(output valid, status, slot, found_type, found_card, found_channel,
		wait_ms, cancel_count, total_count, live_count, due_count, input ready);
	modport sink(input valid, status, slot, found_type, found_card, found_channel,
		wait_ms, cancel_count, total_count, live_count, due_count, output ready);
endinterface

interface ptt_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

### design/periodic_timer_table_unit.sv
// periodic timer table: entries in one ram, scanned one slot per cycle
// tick, create, unused kinds: no scan; state goes straight to response, then the result is registered
// queries scan used slots in order, one read a cycle
// first-hit queries stop at the hit; one item in flight at a time
// reset clears time, used count and limit; ram is never cleared, as slots beyond
// the used count are not read
module periodic_timer_table_unit import ptt_pkg::*; #(
	parameter int DEPTH = PTT_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	ptt_req_if.sink   req,
	ptt_rsp_if.source rsp,
	ptt_cfg_if.sink   cfg
);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [1:0]    state_q;
	logic [31:0]   now_q;
	logic [CW-1:0] used_q;
	logic [7:0]    limit_q;
	logic [3:0]    kind_q;
	logic [3:0]    type_q;
	logic [8:0]    card_q;
	logic [16:0]   chan_q;
	logic [CW-1:0] rd_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          found_q;
	logic          full_q;
	logic [CW-1:0] slot_q;
	logic [3:0]    ftype_q;
	logic [7:0]    fcard_q;
	logic [15:0]   fchan_q;
	logic          any_q;
	logic [31:0]   best_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] m_q;

	logic          out_vld_q;
	logic [1:0]    o_status_q;
	logic [6:0]    o_slot_q;
	logic [3:0]    o_type_q;
	logic [7:0]    o_card_q;
	logic [15:0]   o_chan_q;
	logic [31:0]   o_wait_q;
	logic [7:0]    o_cancel_q;
	logic [7:0]    o_total_q;
	logic [7:0]    o_live_q;
	logic [7:0]    o_due_q;

	entry_t        rdata;
	entry_t        wdata;
	logic          we;
	logic [IW-1:0] waddr;
	eval_t         ev;

	logic          accept;
	logic          is_full;
	logic          first_kind;
	logic          hit;
	logic          issue;
	logic          scan_end;
	logic          resp_load;
	logic [CW+7:0] slot_ext;
	logic [CW+7:0] n_ext;
	logic [CW+7:0] m_ext;
	logic [CW+7:0] used_ext;
	logic [CW+7:0] lim_ext;

	logic [1:0]    st_d;
	logic [6:0]    slot_d;
	logic [3:0]    type_d;
	logic [7:0]    card_d;
	logic [15:0]   chan_d;
	logic [31:0]   wait_d;
	logic [7:0]    cancel_d;
	logic [7:0]    total_d;
	logic [7:0]    live_d;
	logic [7:0]    due_d;

	ptt_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_q[IW-1:0]),
		.rdata(rdata)
	);

	ptt_eval u_eval (
		.entry  (rdata),
		.op_type(type_q),
		.op_card(card_q),
		.op_chan(chan_q),
		.now    (now_q),
		.ev     (ev)
	);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && req.ready;

	always_comb begin
		used_ext   = {8'd0, used_q};
		lim_ext    = {{CW{1'b0}}, limit_q};
		is_full    = ((limit_q != 8'd0) && (used_ext >= lim_ext)) || (used_q >= DEPTH_C);
		first_kind = (kind_q == K_POLL) || (kind_q == K_POLL_ANY) ||
			(kind_q == K_IS_DUE) || (kind_q == K_CANCEL);
		case (kind_q)
			K_POLL_ANY: hit = ev.live && ev.due;
			K_CANCEL:   hit = ev.match;
			default:    hit = ev.match && ev.due;
		endcase
		hit      = hit && vld_s1 && first_kind;
		issue    = (state_q == S_SCAN) && !hit && (rd_q < used_q);
		scan_end = (state_q == S_SCAN) && (hit || (!vld_s1 && (rd_q >= used_q)));
		resp_load = (state_q == S_RESP) && (!out_vld_q || rsp.ready);
		slot_ext = {8'd0, slot_q};
		n_ext    = {8'd0, n_q};
		m_ext    = {8'd0, m_q};
	end

	always_comb begin
		st_d     = ST_OK;
		slot_d   = '0;
		type_d   = '0;
		card_d   = '0;
		chan_d   = '0;
		wait_d   = '0;
		cancel_d = '0;
		total_d  = '0;
		live_d   = '0;
		due_d    = '0;
		case (kind_q)
			K_CREATE: begin
				st_d   = full_q ? ST_FULL : ST_OK;
				slot_d = full_q ? 7'd0 : slot_ext[6:0];
			end
			K_POLL, K_POLL_ANY: begin
				st_d = found_q ? ST_OK : ST_NONE;
				if (found_q) begin
					slot_d = slot_ext[6:0];
					type_d = ftype_q;
					card_d = fcard_q;
					chan_d = fchan_q;
				end
			end
			K_IS_DUE, K_CANCEL: begin
				st_d   = found_q ? ST_OK : ST_NONE;
				slot_d = found_q ? slot_ext[6:0] : 7'd0;
			end
			K_UNTIL: begin
				st_d   = any_q ? ST_OK : ST_NONE;
				wait_d = any_q ? best_q : 32'hFFFF_FFFF;
			end
			K_CANCEL_T: cancel_d = n_ext[7:0];
			K_STATS: begin
				total_d = used_ext[7:0];
				live_d  = n_ext[7:0];
				due_d   = m_ext[7:0];
			end
			default: st_d = ST_OK;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = rdata;
		if (accept && (req.kind == K_CREATE) && !is_full) begin
			we             = 1'b1;
			waddr          = used_q[IW-1:0];
			wdata.live     = 1'b1;
			wdata.etype    = req.timer_type;
			wdata.card     = req.card_sel[7:0];
			wdata.chan     = req.channel_sel[15:0];
			wdata.period   = req.period_ms;
			wdata.deadline = now_q + {1'b0, req.period_ms};
		end else if (hit && ((kind_q == K_POLL) || (kind_q == K_POLL_ANY))) begin
			we             = 1'b1;
			wdata.deadline = rdata.deadline + {1'b0, rdata.period};
		end else if (hit && (kind_q == K_CANCEL)) begin
			we         = 1'b1;
			wdata.live = 1'b0;
		end else if ((state_q == S_SCAN) && vld_s1 && (kind_q == K_CANCEL_T) && ev.type_hit) begin
			we         = 1'b1;
			wdata.live = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			now_q     <= '0;
			used_q    <= '0;
			limit_q   <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.data;
			end
			if (resp_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			vld_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.kind == K_TICK) begin
							now_q <= now_q + 32'd1;
						end
						if ((req.kind == K_CREATE) && !is_full) begin
							used_q <= used_q + CW'(1);
						end
						case (req.kind)
							K_POLL, K_POLL_ANY, K_IS_DUE, K_UNTIL, K_CANCEL, K_CANCEL_T,
							K_STATS: state_q <= S_SCAN;
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.kind;
			type_q  <= req.timer_type;
			card_q  <= req.card_sel;
			chan_q  <= req.channel_sel;
			rd_q    <= '0;
			found_q <= 1'b0;
			full_q  <= is_full;
			slot_q  <= used_q;
			any_q   <= 1'b0;
			best_q  <= '0;
			n_q     <= '0;
			m_q     <= '0;
		end
		if (issue) begin
			rd_q <= rd_q + CW'(1);
		end
		idx_s1 <= rd_q[IW-1:0];
		if ((state_q == S_SCAN) && vld_s1) begin
			if (hit) begin
				found_q <= 1'b1;
				slot_q  <= CW'(idx_s1);
				ftype_q <= rdata.etype;
				fcard_q <= rdata.card;
				fchan_q <= rdata.chan;
			end
			if ((kind_q == K_UNTIL) && ev.match) begin
				any_q <= 1'b1;
				if (!any_q || (ev.gap < best_q)) begin
					best_q <= ev.gap;
				end
			end
			if ((kind_q == K_CANCEL_T) && ev.type_hit) begin
				n_q <= n_q + CW'(1);
			end
			if ((kind_q == K_STATS) && ev.live) begin
				n_q <= n_q + CW'(1);
				if (ev.due) begin
					m_q <= m_q + CW'(1);
				end
			end
		end
		if (resp_load) begin
			o_status_q <= st_d;
			o_slot_q   <= slot_d;
			o_type_q   <= type_d;
			o_card_q   <= card_d;
			o_chan_q   <= chan_d;
			o_wait_q   <= wait_d;
			o_cancel_q <= cancel_d;
			o_total_q  <= total_d;
			o_live_q   <= live_d;
			o_due_q    <= due_d;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = o_status_q;
	assign rsp.slot          = o_slot_q;
	assign rsp.found_type    = o_type_q;
	assign rsp.found_card    = o_card_q;
	assign rsp.found_channel = o_chan_q;
	assign rsp.wait_ms       = o_wait_q;
	assign rsp.cancel_count  = o_cancel_q;
	assign rsp.total_count   = o_total_q;
	assign rsp.live_count    = o_live_q;
	assign rsp.due_count     = o_due_q;
endmodule

### design/ptt_ram.sv
// generic simple dual-port ram with registered read
module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### design/ptt_eval.sv
// per-entry match, due and distance evaluation
module ptt_eval import ptt_pkg::*; (
	input  entry_t      entry,
	input  logic [3:0]  op_type,
	input  logic [8:0]  op_card,
	input  logic [16:0] op_chan,
	input  logic [31:0] now,
	output eval_t       ev
);
	logic [31:0] age;
	logic [31:0] left;
	logic        card_ok;
	logic        chan_ok;

	always_comb begin
		age      = now - entry.deadline;
		left     = entry.deadline - now;
		card_ok  = (op_card == 9'h1FF) || (op_card[7:0] == entry.card);
		chan_ok  = (op_chan == 17'h1FFFF) || (op_chan[15:0] == entry.chan);
		ev.live     = entry.live;
		ev.type_hit = entry.live && (entry.etype == op_type);
		ev.match    = ev.type_hit && card_ok && chan_ok;
		ev.due      = !age[31];
		ev.gap      = left[31] ? 32'd0 : left;
	end
endmodule

### bench/ptt_checker.sv
// watches the timer table channels, predicts every response beat and compares
module ptt_checker import ptt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ptt_req_if   req,
	ptt_rsp_if   rsp,
	ptt_cfg_if   cfg,
	output int   errors,
	output int   pending,
	output int   checked
);

	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         slot;
		logic [3:0]         ftype;
		logic [7:0]         fcard;
		logic [15:0]        fchan;
		logic signed [31:0] wait_ms;
		logic [7:0]         cancel_n;
		logic [7:0]         total_n;
		logic [7:0]         live_n;
		logic [7:0]         due_n;
	} answer_t;

	answer_t     answers[$];
	logic [31:0] now_ms;
	int          used;
	logic [7:0]  limit;
	logic        live[PTT_DEPTH];
	logic [3:0]  etype[PTT_DEPTH];
	logic [7:0]  ecard[PTT_DEPTH];
	logic [15:0] echan[PTT_DEPTH];
	logic [30:0] eperiod[PTT_DEPTH];
	logic [31:0] edead[PTT_DEPTH];

	function automatic logic hit(int i, logic [3:0] t, logic [8:0] c, logic [16:0] ch);
		return live[i] && etype[i] == t && (c == 9'h1ff || ecard[i] == c[7:0])
			&& (ch == 17'h1ffff || echan[i] == ch[15:0]);
	endfunction

	function automatic logic overdue(int i);
		logic [31:0] d;
		d = now_ms - edead[i];
		return !d[31];
	endfunction

	task automatic timer_table_step(input logic [3:0] k, input logic [3:0] t,
		input logic [8:0] c, input logic [16:0] ch, input logic [30:0] p,
		output answer_t a);
		logic        any;
		logic        h;
		logic [31:0] d;
		logic [31:0] best;
		int          n;
		int          m;
		a = '0;
		any = 0;
		best = 0;
		n = 0;
		m = 0;
		case (k)
			K_TICK: now_ms = now_ms + 1;
			K_CREATE: begin
				if ((limit != 0 && used >= limit) || used >= PTT_DEPTH) begin
					a.status = ST_FULL;
				end else begin
					live[used] = 1;
					etype[used] = t;
					ecard[used] = c[7:0];
					echan[used] = ch[15:0];
					eperiod[used] = p;
					edead[used] = now_ms + {1'b0, p};
					a.slot = used[6:0];
					used++;
				end
			end
			K_POLL, K_POLL_ANY, K_IS_DUE: begin
				a.status = ST_NONE;
				for (int i = 0; i < used; i++) begin
					h = (k == K_POLL_ANY) ? live[i] : hit(i, t, c, ch);
					if (h && overdue(i)) begin
						a.status = ST_OK;
						a.slot = i[6:0];
						if (k != K_IS_DUE) begin
							a.ftype = etype[i];
							a.fcard = ecard[i];
							a.fchan = echan[i];
							edead[i] = edead[i] + {1'b0, eperiod[i]};
						end
						break;
					end
				end
			end
			K_UNTIL: begin
				for (int i = 0; i < used; i++) begin
					if (hit(i, t, c, ch)) begin
						d = edead[i] - now_ms;
						if (d[31]) d = 0;
						if (!any || d < best) best = d;
						any = 1;
					end
				end
				a.status = any ? ST_OK : ST_NONE;
				a.wait_ms = any ? best : -32'sd1;
			end
			K_CANCEL: begin
				a.status = ST_NONE;
				for (int i = 0; i < used; i++) begin
					if (hit(i, t, c, ch)) begin
						live[i] = 0;
						a.status = ST_OK;
						a.slot = i[6:0];
						break;
					end
				end
			end
			K_CANCEL_T: begin
				for (int i = 0; i < used; i++) begin
					if (live[i] && etype[i] == t) begin
						live[i] = 0;
						n++;
					end
				end
				a.cancel_n = n[7:0];
			end
			K_STATS: begin
				for (int i = 0; i < used; i++) begin
					if (live[i]) begin
						n++;
						if (overdue(i)) m++;
					end
				end
				a.total_n = used[7:0];
				a.live_n = n[7:0];
				a.due_n = m[7:0];
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		answer_t got;
		if (!arst_n) begin
			now_ms = 0;
			used = 0;
			limit = 0;
			errors = 0;
			checked = 0;
			answers.delete();
			for (int i = 0; i < PTT_DEPTH; i++) live[i] = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.slot, rsp.found_type, rsp.found_card,
					rsp.found_channel, rsp.wait_ms, rsp.cancel_count, rsp.total_count,
					rsp.live_count, rsp.due_count};
				if (answers.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat %p", $time, got);
				end else begin
					a = answers.pop_front();
					checked++;
					if (got !== a) begin
						errors++;
						$display("%0t: mismatch expected %p actual %p", $time, a, got);
					end
				end
			end
			if (req.valid && req.ready) begin
				timer_table_step(req.kind, req.timer_type, req.card_sel, req.channel_sel,
					req.period_ms, a);
				answers.push_back(a);
			end
			if (cfg.valid && cfg.ready) limit = cfg.data;
		end
		pending = answers.size();
	end

endmodule

### bench/testbench.sv
// top of the timer table bench: clock, reset, stimulus and verdict
module testbench import ptt_pkg::*;;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   checked;
	int   send_idle;
	int   recv_idle;
	int   hold_ask;
	int   hold_left;
	int   beats_sent;
	longint cycles;

	ptt_req_if req_ch();
	ptt_rsp_if rsp_ch();
	ptt_cfg_if cfg_ch();

	periodic_timer_table_unit u_top (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
	);

	ptt_checker u_chk (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1000000) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// response side: random stalls plus long hold-offs on request
	initial begin
		rsp_ch.ready = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_ask > 0) begin
				hold_left = hold_ask;
				hold_ask = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready = 0;
			end else begin
				rsp_ch.ready = $urandom_range(99) >= recv_idle;
			end
		end
	end

	task automatic send(input logic [3:0] k, input logic [3:0] t, input logic [8:0] c,
		input logic [16:0] ch, input logic [30:0] p);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid = 0;
			@(negedge clk);
		end
		req_ch.kind = k;
		req_ch.timer_type = t;
		req_ch.card_sel = c;
		req_ch.channel_sel = ch;
		req_ch.period_ms = p;
		req_ch.valid = 1;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic set_limit(input logic [7:0] v);
		drain();
		cfg_ch.data = v;
		cfg_ch.valid = 1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 0;
	endtask

	task automatic random_item();
		logic [3:0]  k;
		logic [3:0]  t;
		logic [8:0]  c;
		logic [16:0] ch;
		logic [30:0] p;
		int          r;
		r = $urandom_range(99);
		if (r < 30) k = K_TICK;
		else if (r < 46) k = K_CREATE;
		else if (r < 56) k = K_POLL;
		else if (r < 65) k = K_POLL_ANY;
		else if (r < 72) k = K_IS_DUE;
		else if (r < 80) k = K_UNTIL;
		else if (r < 86) k = K_CANCEL;
		else if (r < 89) k = K_CANCEL_T;
		else if (r < 95) k = K_STATS;
		else k = 4'($urandom_range(15, 9));
		t = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(3));
		case ($urandom_range(5))
			0: c = 9'h1ff;
			1: c = 9'd255;
			2: c = 9'($urandom);
			default: c = 9'($urandom_range(2));
		endcase
		case ($urandom_range(5))
			0: ch = 17'h1ffff;
			1: ch = 17'd65535;
			2: ch = 17'($urandom);
			default: ch = 17'($urandom_range(2));
		endcase
		case ($urandom_range(9))
			0: p = 31'($urandom);
			1: p = 31'h7fffffff;
			default: p = 31'($urandom_range(25));
		endcase
		send(k, t, c, ch, p);
	endtask

	initial begin
		arst_n = 0;
		req_ch.valid = 0;
		req_ch.kind = K_TICK;
		req_ch.timer_type = 0;
		req_ch.card_sel = 0;
		req_ch.channel_sel = 0;
		req_ch.period_ms = 0;
		cfg_ch.valid = 0;
		cfg_ch.data = 0;
		send_idle = 0;
		recv_idle = 0;
		hold_ask = 0;
		beats_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		set_limit(8'd2);
		send(K_CREATE, 4'd1, 9'h1ff, 17'h1ffff, 31'd0);
		send(K_CREATE, 4'd2, 9'd255, 17'd65535, 31'h7fffffff);
		send(K_CREATE, 4'd3, 9'd0, 17'd0, 31'd1);
		send(K_POLL, 4'd1, 9'd255, 17'd65535, 31'd0);
		send(K_POLL_ANY, 4'd0, 9'd0, 17'd0, 31'd0);
		send(K_IS_DUE, 4'd1, 9'h1ff, 17'h1ffff, 31'd0);
		send(K_IS_DUE, 4'd2, 9'h1ff, 17'h1ffff, 31'd0);
		send(K_POLL, 4'd2, 9'h1ff, 17'h1ffff, 31'd0);
		send(K_UNTIL, 4'd2, 9'h1ff, 17'h1ffff, 31'd0);
		send(K_UNTIL, 4'd1, 9'd255, 17'h1ffff, 31'd0);
		send(K_UNTIL, 4'd15, 9'h1ff, 17'h1ffff, 31'd0);
		send(K_TICK, 4'd0, 9'd0, 17'd0, 31'd0);
		send(K_STATS, 4'd0, 9'd0, 17'd0, 31'd0);
		send(K_CANCEL, 4'd1, 9'h1ff, 17'h1ffff, 31'd0);
		send(K_CANCEL, 4'd1, 9'h1ff, 17'h1ffff, 31'd0);
		send(K_CANCEL_T, 4'd2, 9'd0, 17'd0, 31'd0);
		send(K_STATS, 4'd0, 9'd0, 17'd0, 31'd0);
		send(4'd9, 4'd0, 9'd0, 17'd0, 31'd0);
		send(4'd15, 4'd15, 9'h1ff, 17'h1ffff, 31'h7fffffff);
		set_limit(8'd1);
		send(K_CREATE, 4'd0, 9'd0, 17'd0, 31'd5);
		send(K_STATS, 4'd0, 9'd0, 17'd0, 31'd0);

		set_limit(8'd40);
		send_idle = 34;
		recv_idle = 77;
		for (int i = 0; i < 530; i++) begin
			if (i == 200) hold_ask = 600;
			random_item();
		end
		set_limit(8'd128);
		send_idle = 77;
		recv_idle = 34;
		for (int i = 0; i < 530; i++) random_item();
		set_limit(8'd0);
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 540; i++) random_item();

		req_ch.valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		$display("ran %0d requests through five limit settings and three stall mixes",
			beats_sent);
		$display("%0d response beats compared, %0d errors", checked, errors);
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
